// File: design/ioir_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and sizing constants of the I/O interrupt redirector.
// No dependencies; every other design file but ioir_ram refers to it by scoped names.
package ioir_pkg;

  localparam int TABLE_ENTRIES = 24;
  localparam int NUM_GUESTS    = 4;
  localparam int TBL_DEPTH     = NUM_GUESTS * TABLE_ENTRIES;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int GUEST_W       = (NUM_GUESTS > 1) ? $clog2(NUM_GUESTS) : 1;
  localparam int ADDR_W        = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam int ENTRY_W       = 64;
  localparam int CFG_IDX_W     = 2;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [GUEST_W-1:0] guest_idx_t;
  typedef logic [ADDR_W-1:0]  tbl_addr_t;
  typedef logic [ENTRY_W-1:0] entry_t;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_RAISE = 2'd2,
    REQ_LOWER = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_OFFSET  = 2'd1,
    ST_UNDEF_REG   = 2'd2,
    ST_LOWEST_PHYS = 2'd3
  } status_t;

  localparam logic [4:0] OFF_INDEX  = 5'd0;
  localparam logic [4:0] OFF_WINDOW = 5'd16;

  localparam logic [7:0] SEL_ID       = 8'h00;
  localparam logic [7:0] SEL_VERSION  = 8'h01;
  localparam logic [7:0] SEL_ARB      = 8'h02;
  localparam logic [7:0] SEL_TBL_BASE = 8'h10;

  localparam logic [2:0] MODE_LOWEST = 3'd1;
  localparam logic [2:0] MODE_EXTINT = 3'd7;
  localparam logic [7:0] DEST_BROADCAST = 8'hFF;

  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_ID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION    = 2'd1;

  localparam logic [7:0]  VERSION_RESET     = 8'd17;
  localparam logic [15:0] VERSION_MAX_ENTRY = 16'(TABLE_ENTRIES - 1);

  // entry layout
  localparam int E_MODE_LO = 8;
  localparam int E_DMODE   = 11;
  localparam int E_POL     = 13;
  localparam int E_TRIG    = 15;
  localparam int E_MASK    = 16;
  localparam int E_DEST_LO = 56;

  localparam entry_t ENTRY_RESET = entry_t'(1) << E_MASK;

  typedef struct packed {
    logic load;
    logic lookup;
    logic exec;
  } cmd_t;

endpackage

// File: design/io_interrupt_redirector.sv
`timescale 1ns / 1ps
// Top level of the I/O interrupt redirector: controller plus datapath.
// Depends on ioir_pkg, ioir_ctrl, ioir_dp and ioir_ram.
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------------
//  in      | in_valid / in_stall    | req_type, guest, bus_offset, write_data, pin,
//          |                        | ext_vector
//  out     | out_valid / out_stall  | read_data, int_* message fields, status
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Each transaction steps through accept, table read, execute and present result.
// The table read step serves the registered read of the table RAM ahead of its read-modify-write.
// A new transaction is accepted in the cycle after the result is taken.
// Reset is synchronous, active low; table valid bits clear at once, no clearing pass.
// out_stall holds the result; in_stall is high whenever a transaction is in flight.
module io_interrupt_redirector (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_req_type,
  input  logic [1:0]                     in_guest,
  input  logic [4:0]                     in_bus_offset,
  input  logic [31:0]                    in_write_data,
  input  logic [4:0]                     in_pin,
  input  logic [7:0]                     in_ext_vector,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [31:0]                    out_read_data,
  output logic                           out_int_valid,
  output logic [7:0]                     out_int_vector,
  output logic [7:0]                     out_int_dest,
  output logic [2:0]                     out_int_delivery_mode,
  output logic                           out_int_dest_mode,
  output logic                           out_int_level,
  output logic                           out_int_trigger,
  output logic                           out_int_broadcast,
  output logic [1:0]                     out_status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ioir_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);

  ioir_pkg::cmd_t cmd;

  ioir_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  ioir_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .in_req_type           (in_req_type),
    .in_guest              (in_guest),
    .in_bus_offset         (in_bus_offset),
    .in_write_data         (in_write_data),
    .in_pin                (in_pin),
    .in_ext_vector         (in_ext_vector),
    .cfg_we                (cfg_valid && cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .out_read_data         (out_read_data),
    .out_int_valid         (out_int_valid),
    .out_int_vector        (out_int_vector),
    .out_int_dest          (out_int_dest),
    .out_int_delivery_mode (out_int_delivery_mode),
    .out_int_dest_mode     (out_int_dest_mode),
    .out_int_level         (out_int_level),
    .out_int_trigger       (out_int_trigger),
    .out_int_broadcast     (out_int_broadcast),
    .out_status            (out_status)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("transaction accepted while another is in flight");

  a_exec_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid)
    else $error("executed transaction did not present a result");

  a_msg_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_int_valid |-> out_status == ioir_pkg::ST_OK)
    else $error("interrupt message with nonzero status");

  a_msg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_int_valid |-> out_int_vector == 8'd0 && out_int_dest == 8'd0 &&
                                    !out_int_broadcast)
    else $error("message fields set without a message");

  a_no_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !cfg_ready && in_stall)
    else $error("ports open while a result is pending");

endmodule

// File: design/ioir_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Standalone; sized by its WIDTH and DEPTH parameters.
module ioir_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 96,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/ioir_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the redirector: accept, table lookup, execute, present result.
// Uses ioir_pkg for the command struct.
module ioir_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           cfg_ready,
  output ioir_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_EXEC = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_LOOK;
      S_LOOK: state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_OUT;
      S_OUT:  if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall   = (state_r != S_IDLE);
  assign cfg_ready  = (state_r == S_IDLE);
  assign out_valid  = (state_r == S_OUT);
  assign cmd.load   = (state_r == S_IDLE) && in_valid;
  assign cmd.lookup = (state_r == S_LOOK);
  assign cmd.exec   = (state_r == S_EXEC);

endmodule

// File: design/ioir_dp.sv
`timescale 1ns / 1ps
// Datapath of the redirector: transaction latch, registers, redirection table.
// Uses ioir_pkg and instantiates ioir_ram for the table.
module ioir_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ioir_pkg::cmd_t                 cmd,
  input  logic [1:0]                     in_req_type,
  input  logic [1:0]                     in_guest,
  input  logic [4:0]                     in_bus_offset,
  input  logic [31:0]                    in_write_data,
  input  logic [4:0]                     in_pin,
  input  logic [7:0]                     in_ext_vector,
  input  logic                           cfg_we,
  input  logic [ioir_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  output logic [31:0]                    out_read_data,
  output logic                           out_int_valid,
  output logic [7:0]                     out_int_vector,
  output logic [7:0]                     out_int_dest,
  output logic [2:0]                     out_int_delivery_mode,
  output logic                           out_int_dest_mode,
  output logic                           out_int_level,
  output logic                           out_int_trigger,
  output logic                           out_int_broadcast,
  output logic [1:0]                     out_status
);

  typedef struct packed {
    logic [31:0]       read_data;
    logic              int_valid;
    logic [7:0]        int_vector;
    logic [7:0]        int_dest;
    logic [2:0]        int_delivery_mode;
    logic              int_dest_mode;
    logic              int_level;
    logic              int_trigger;
    logic              int_broadcast;
    ioir_pkg::status_t status;
  } res_t;

  ioir_pkg::req_t req_r;
  logic [1:0]     guest_r;
  logic [4:0]     offset_r;
  logic [31:0]    wdata_r;
  logic [4:0]     pin_r;
  logic [7:0]     ext_r;

  logic [7:0] sel_r   [ioir_pkg::NUM_GUESTS];
  logic [7:0] sel_nxt [ioir_pkg::NUM_GUESTS];
  logic [7:0] apic_id_r, apic_id_nxt;
  logic [7:0] arb_id_r, arb_id_nxt;
  logic [7:0] initial_id_r, initial_id_nxt;
  logic [7:0] version_r, version_nxt;
  logic [ioir_pkg::TABLE_ENTRIES-1:0] pins_r, pins_nxt;
  logic [ioir_pkg::TBL_DEPTH-1:0]     vld_r;
  logic                               vld_q_r;
  res_t                               res_r, res_nxt;

  ioir_pkg::guest_idx_t gidx;
  ioir_pkg::idx_t       pidx;
  ioir_pkg::idx_t       sidx;
  ioir_pkg::idx_t       tidx;
  ioir_pkg::tbl_addr_t  addr;
  logic                 guest_ok;
  logic                 pin_ok;
  logic                 is_pin;
  logic [7:0]           sel_cur;
  logic [7:0]           sel_off;
  logic                 sel_in_tbl;
  ioir_pkg::entry_t     ram_q;
  ioir_pkg::entry_t     entry;
  ioir_pkg::entry_t     wentry;
  logic                 tbl_we;
  logic [2:0]           mode;
  logic                 dmode;
  logic [7:0]           dest;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r    <= ioir_pkg::req_t'(in_req_type);
      guest_r  <= in_guest;
      offset_r <= in_bus_offset;
      wdata_r  <= in_write_data;
      pin_r    <= in_pin;
      ext_r    <= in_ext_vector;
    end
  end

  assign gidx       = ioir_pkg::guest_idx_t'(guest_r);
  assign pidx       = ioir_pkg::idx_t'(pin_r);
  assign guest_ok   = int'(guest_r) < ioir_pkg::NUM_GUESTS;
  assign pin_ok     = int'(pin_r) < ioir_pkg::TABLE_ENTRIES;
  assign is_pin     = (req_r == ioir_pkg::REQ_RAISE) || (req_r == ioir_pkg::REQ_LOWER);
  assign sel_cur    = sel_r[gidx];
  assign sel_off    = sel_cur - ioir_pkg::SEL_TBL_BASE;
  assign sidx       = ioir_pkg::idx_t'(sel_off[7:1]);
  assign sel_in_tbl = (sel_cur >= ioir_pkg::SEL_TBL_BASE) &&
                      (int'(sel_cur) < int'(ioir_pkg::SEL_TBL_BASE) +
                                       2 * ioir_pkg::TABLE_ENTRIES);
  assign tidx       = is_pin ? pidx : sidx;
  assign addr       = ioir_pkg::tbl_addr_t'(int'(gidx) * ioir_pkg::TABLE_ENTRIES +
                                            int'(tidx));

  ioir_ram #(
    .WIDTH (ioir_pkg::ENTRY_W),
    .DEPTH (ioir_pkg::TBL_DEPTH)
  ) u_tbl (
    .clk   (clk),
    .we    (cmd.exec && tbl_we),
    .waddr (addr),
    .wdata (wentry),
    .re    (cmd.lookup),
    .raddr (addr),
    .rdata (ram_q)
  );

  assign entry = vld_q_r ? ram_q : ioir_pkg::ENTRY_RESET;
  assign mode  = entry[ioir_pkg::E_MODE_LO +: 3];
  assign dmode = entry[ioir_pkg::E_DMODE];
  assign dest  = entry[ioir_pkg::E_DEST_LO +: 8];

  always_comb begin
    res_nxt        = '0;
    res_nxt.status = ioir_pkg::ST_OK;
    tbl_we         = 1'b0;
    wentry         = entry;
    sel_nxt        = sel_r;
    apic_id_nxt    = apic_id_r;
    arb_id_nxt     = arb_id_r;
    initial_id_nxt = initial_id_r;
    version_nxt    = version_r;
    pins_nxt       = pins_r;

    if (cmd.exec && guest_ok) begin
      unique case (req_r)
        ioir_pkg::REQ_READ, ioir_pkg::REQ_WRITE: begin
          if (offset_r == ioir_pkg::OFF_INDEX) begin
            if (req_r == ioir_pkg::REQ_READ) begin
              res_nxt.read_data = {24'b0, sel_cur};
            end else begin
              sel_nxt[gidx] = wdata_r[7:0];
            end
          end else if (offset_r == ioir_pkg::OFF_WINDOW) begin
            priority if (sel_cur == ioir_pkg::SEL_ID) begin
              if (req_r == ioir_pkg::REQ_READ) res_nxt.read_data = {apic_id_r, 24'b0};
              else apic_id_nxt = wdata_r[31:24];
            end else if (sel_cur == ioir_pkg::SEL_VERSION) begin
              if (req_r == ioir_pkg::REQ_READ) begin
                res_nxt.read_data = {ioir_pkg::VERSION_MAX_ENTRY, 8'b0, version_r};
              end
            end else if (sel_cur == ioir_pkg::SEL_ARB) begin
              if (req_r == ioir_pkg::REQ_READ) res_nxt.read_data = {arb_id_r, 24'b0};
              else arb_id_nxt = wdata_r[31:24];
            end else if (sel_in_tbl) begin
              if (req_r == ioir_pkg::REQ_READ) begin
                res_nxt.read_data = sel_cur[0] ? entry[63:32] : entry[31:0];
              end else begin
                tbl_we = 1'b1;
                if (sel_cur[0]) wentry = {wdata_r[31:24], 24'b0, entry[31:0]};
                else wentry = {entry[63:32], 15'b0, wdata_r[16:0]};
              end
            end else begin
              res_nxt.status = ioir_pkg::ST_UNDEF_REG;
            end
          end else begin
            res_nxt.status = ioir_pkg::ST_BAD_OFFSET;
          end
        end
        ioir_pkg::REQ_RAISE: begin
          if (pin_ok) begin
            pins_nxt[pidx] = 1'b1;
            if (!pins_r[pidx] && !entry[ioir_pkg::E_MASK]) begin
              if (!dmode && (mode == ioir_pkg::MODE_LOWEST)) begin
                res_nxt.status = ioir_pkg::ST_LOWEST_PHYS;
              end else begin
                res_nxt.int_valid         = 1'b1;
                res_nxt.int_vector        = (mode == ioir_pkg::MODE_EXTINT) ? ext_r
                                                                            : entry[7:0];
                res_nxt.int_dest          = dest;
                res_nxt.int_delivery_mode = mode;
                res_nxt.int_dest_mode     = dmode;
                res_nxt.int_level         = entry[ioir_pkg::E_POL];
                res_nxt.int_trigger       = entry[ioir_pkg::E_TRIG];
                res_nxt.int_broadcast     = !dmode && (dest == ioir_pkg::DEST_BROADCAST);
              end
            end
          end
        end
        ioir_pkg::REQ_LOWER: begin
          if (pin_ok) pins_nxt[pidx] = 1'b0;
        end
        default: ;
      endcase
    end

    if (cfg_we) begin
      if (cfg_index == ioir_pkg::CFG_INITIAL_ID) begin
        initial_id_nxt = cfg_data;
        apic_id_nxt    = cfg_data;
        arb_id_nxt     = cfg_data;
      end else if (cfg_index == ioir_pkg::CFG_VERSION) begin
        version_nxt = cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int g = 0; g < ioir_pkg::NUM_GUESTS; g++) sel_r[g] <= '0;
      apic_id_r    <= '0;
      arb_id_r     <= '0;
      initial_id_r <= '0;
      version_r    <= ioir_pkg::VERSION_RESET;
      pins_r       <= '0;
      vld_r        <= '0;
    end else begin
      sel_r        <= sel_nxt;
      apic_id_r    <= apic_id_nxt;
      arb_id_r     <= arb_id_nxt;
      initial_id_r <= initial_id_nxt;
      version_r    <= version_nxt;
      pins_r       <= pins_nxt;
      if (cmd.exec && tbl_we) vld_r[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) vld_q_r <= vld_r[addr];
    if (cmd.exec) res_r <= res_nxt;
  end

  assign out_read_data         = res_r.read_data;
  assign out_int_valid         = res_r.int_valid;
  assign out_int_vector        = res_r.int_vector;
  assign out_int_dest          = res_r.int_dest;
  assign out_int_delivery_mode = res_r.int_delivery_mode;
  assign out_int_dest_mode     = res_r.int_dest_mode;
  assign out_int_level         = res_r.int_level;
  assign out_int_trigger       = res_r.int_trigger;
  assign out_int_broadcast     = res_r.int_broadcast;
  assign out_status            = res_r.status;

endmodule

// File: verif/ioir_checker.sv
`timescale 1ns / 1ps
// Checker for the I/O interrupt redirector: watches the request, result and config channels,
// predicts every result from its own copy of the tables and registers, and compares.
// Depends on ioir_pkg.
module ioir_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [1:0]                     in_req_type,
  input  logic [1:0]                     in_guest,
  input  logic [4:0]                     in_bus_offset,
  input  logic [31:0]                    in_write_data,
  input  logic [4:0]                     in_pin,
  input  logic [7:0]                     in_ext_vector,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [31:0]                    out_read_data,
  input  logic                           out_int_valid,
  input  logic [7:0]                     out_int_vector,
  input  logic [7:0]                     out_int_dest,
  input  logic [2:0]                     out_int_delivery_mode,
  input  logic                           out_int_dest_mode,
  input  logic                           out_int_level,
  input  logic                           out_int_trigger,
  input  logic                           out_int_broadcast,
  input  logic [1:0]                     out_status,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [ioir_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  output int unsigned                    mismatches,
  output int unsigned                    outstanding,
  output int unsigned                    irq_count
);

  localparam int unsigned MAX_REPORTS = 50;

  typedef struct packed {
    logic [31:0]       read_data;
    logic              int_valid;
    logic [7:0]        int_vector;
    logic [7:0]        int_dest;
    logic [2:0]        int_delivery_mode;
    logic              int_dest_mode;
    logic              int_level;
    logic              int_trigger;
    logic              int_broadcast;
    ioir_pkg::status_t status;
  } response_t;

  ioir_pkg::entry_t redir_table [ioir_pkg::NUM_GUESTS][ioir_pkg::TABLE_ENTRIES];
  logic [7:0]       select_latch [ioir_pkg::NUM_GUESTS];
  logic [7:0]       apic_id;
  logic [7:0]       arb_id;
  logic [7:0]       id_setting;
  logic [7:0]       version_setting;
  logic [ioir_pkg::TABLE_ENTRIES-1:0] pin_state;
  response_t        expected_responses [$];

  function automatic response_t redirect_step(ioir_pkg::req_t rq, logic [1:0] g,
                                              logic [4:0] off, logic [31:0] wd,
                                              logic [4:0] p, logic [7:0] ext);
    response_t        r;
    ioir_pkg::entry_t e;
    logic [7:0]       sel;
    int unsigned      n;
    logic             was_high;
    r = '0;
    if (int'(g) >= ioir_pkg::NUM_GUESTS) return r;
    sel = select_latch[g];
    if (rq == ioir_pkg::REQ_READ || rq == ioir_pkg::REQ_WRITE) begin
      if (off == ioir_pkg::OFF_INDEX) begin
        if (rq == ioir_pkg::REQ_READ) r.read_data = 32'(sel);
        else select_latch[g] = wd[7:0];
      end else if (off != ioir_pkg::OFF_WINDOW) begin
        r.status = ioir_pkg::ST_BAD_OFFSET;
      end else if (sel == ioir_pkg::SEL_ID) begin
        if (rq == ioir_pkg::REQ_READ) r.read_data = {apic_id, 24'h0};
        else apic_id = wd[31:24];
      end else if (sel == ioir_pkg::SEL_VERSION) begin
        if (rq == ioir_pkg::REQ_READ)
          r.read_data = {8'h0, 8'(ioir_pkg::TABLE_ENTRIES - 1), 8'h0, version_setting};
      end else if (sel == ioir_pkg::SEL_ARB) begin
        if (rq == ioir_pkg::REQ_READ) r.read_data = {arb_id, 24'h0};
        else arb_id = wd[31:24];
      end else if (sel >= ioir_pkg::SEL_TBL_BASE &&
                   int'(sel) < int'(ioir_pkg::SEL_TBL_BASE) + 2 * ioir_pkg::TABLE_ENTRIES) begin
        n = (int'(sel) - int'(ioir_pkg::SEL_TBL_BASE)) / 2;
        e = redir_table[g][n];
        if (rq == ioir_pkg::REQ_READ) r.read_data = sel[0] ? e[63:32] : e[31:0];
        else if (sel[0]) e[63:32] = {wd[31:24], 24'h0};
        else e[31:0] = {15'h0, wd[16:0]};
        redir_table[g][n] = e;
      end else begin
        r.status = ioir_pkg::ST_UNDEF_REG;
      end
    end else if (int'(p) < ioir_pkg::TABLE_ENTRIES) begin
      if (rq == ioir_pkg::REQ_LOWER) begin
        pin_state[p] = 1'b0;
      end else begin
        was_high = pin_state[p];
        pin_state[p] = 1'b1;
        e = redir_table[g][p];
        if (!was_high && !e[ioir_pkg::E_MASK]) begin
          if (!e[ioir_pkg::E_DMODE] &&
              e[ioir_pkg::E_MODE_LO +: 3] == ioir_pkg::MODE_LOWEST) begin
            r.status = ioir_pkg::ST_LOWEST_PHYS;
          end else begin
            r.int_valid         = 1'b1;
            r.int_vector        = (e[ioir_pkg::E_MODE_LO +: 3] == ioir_pkg::MODE_EXTINT) ?
                                  ext : e[7:0];
            r.int_dest          = e[ioir_pkg::E_DEST_LO +: 8];
            r.int_delivery_mode = e[ioir_pkg::E_MODE_LO +: 3];
            r.int_dest_mode     = e[ioir_pkg::E_DMODE];
            r.int_level         = e[ioir_pkg::E_POL];
            r.int_trigger       = e[ioir_pkg::E_TRIG];
            r.int_broadcast     = !e[ioir_pkg::E_DMODE] &&
                                  e[ioir_pkg::E_DEST_LO +: 8] == ioir_pkg::DEST_BROADCAST;
          end
        end
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches = mismatches + 1;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    response_t got;
    response_t want;
    response_t pred;
    if (!rst_n) begin
      for (int gi = 0; gi < ioir_pkg::NUM_GUESTS; gi++) begin
        select_latch[gi] = 8'h0;
        for (int ei = 0; ei < ioir_pkg::TABLE_ENTRIES; ei++)
          redir_table[gi][ei] = ioir_pkg::ENTRY_RESET;
      end
      id_setting      = 8'h0;
      version_setting = ioir_pkg::VERSION_RESET;
      apic_id         = 8'h0;
      arb_id          = 8'h0;
      pin_state       = '0;
      expected_responses.delete();
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ioir_pkg::CFG_INITIAL_ID) begin
          id_setting = cfg_data;
          apic_id    = cfg_data;
          arb_id     = cfg_data;
        end else if (cfg_index == ioir_pkg::CFG_VERSION) begin
          version_setting = cfg_data;
        end
      end
      if (out_valid && !out_stall) begin
        got = {out_read_data, out_int_valid, out_int_vector, out_int_dest,
               out_int_delivery_mode, out_int_dest_mode, out_int_level, out_int_trigger,
               out_int_broadcast, out_status};
        if (expected_responses.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result with no request pending, got 0x%0h", $time, got);
        end else begin
          want = expected_responses.pop_front();
          if (got.int_valid === 1'b1) irq_count = irq_count + 1;
          check_field("read_data", want.read_data, got.read_data);
          check_field("int_valid", 32'(want.int_valid), 32'(got.int_valid));
          check_field("int_vector", 32'(want.int_vector), 32'(got.int_vector));
          check_field("int_dest", 32'(want.int_dest), 32'(got.int_dest));
          check_field("int_delivery_mode", 32'(want.int_delivery_mode),
                      32'(got.int_delivery_mode));
          check_field("int_dest_mode", 32'(want.int_dest_mode), 32'(got.int_dest_mode));
          check_field("int_level", 32'(want.int_level), 32'(got.int_level));
          check_field("int_trigger", 32'(want.int_trigger), 32'(got.int_trigger));
          check_field("int_broadcast", 32'(want.int_broadcast), 32'(got.int_broadcast));
          check_field("status", 32'(want.status), 32'(got.status));
        end
      end
      if (in_valid && !in_stall) begin
        pred = redirect_step(ioir_pkg::req_t'(in_req_type), in_guest, in_bus_offset,
                             in_write_data, in_pin, in_ext_vector);
        expected_responses.insert(expected_responses.size(), pred);
      end
      outstanding <= expected_responses.size();
    end
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Top of the I/O interrupt redirector testbench: clock, reset, request and config stimulus,
// result-side stalls and the verdict. Depends on ioir_pkg, io_interrupt_redirector, ioir_checker.
module tb_top;

  localparam int unsigned LONG_HOLD   = 64;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [1:0]                     in_req_type = '0;
  logic [1:0]                     in_guest = '0;
  logic [4:0]                     in_bus_offset = '0;
  logic [31:0]                    in_write_data = '0;
  logic [4:0]                     in_pin = '0;
  logic [7:0]                     in_ext_vector = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [31:0]                    out_read_data;
  logic                           out_int_valid;
  logic [7:0]                     out_int_vector;
  logic [7:0]                     out_int_dest;
  logic [2:0]                     out_int_delivery_mode;
  logic                           out_int_dest_mode;
  logic                           out_int_level;
  logic                           out_int_trigger;
  logic                           out_int_broadcast;
  logic [1:0]                     out_status;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [ioir_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]                     cfg_data = '0;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned irq_count;
  int unsigned requests_sent = 0;
  int unsigned cfg_writes = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_pct = 0;
  logic        hold_req = 1'b0;

  always #4 clk = ~clk;

  io_interrupt_redirector DUT (.*);

  ioir_checker checker_i (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[io_interrupt_redirector] ERROR");
      $finish;
    end
  end

  // result side: random stall bursts, plus one long hold on request
  initial begin : receiver
    int unsigned n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req <= 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 8);
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic issue(ioir_pkg::req_t rq, logic [1:0] g, logic [4:0] off, logic [31:0] wd,
                       logic [4:0] p, logic [7:0] ext);
    int unsigned n;
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      in_valid <= 1'b0;
      n = $urandom_range(1, 8);
      repeat (n) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= rq;
    in_guest      <= g;
    in_bus_offset <= off;
    in_write_data <= wd;
    in_pin        <= p;
    in_ext_vector <= ext;
    do @(posedge clk); while (in_stall);
    if (!((rq == ioir_pkg::REQ_RAISE || rq == ioir_pkg::REQ_LOWER) &&
          int'(p) >= ioir_pkg::TABLE_ENTRIES))
      requests_sent++;
  endtask

  task automatic write_index(logic [1:0] g, logic [7:0] sel);
    issue(ioir_pkg::REQ_WRITE, g, ioir_pkg::OFF_INDEX, {24'($urandom), sel}, 5'($urandom),
          8'($urandom));
  endtask

  task automatic window_write(logic [1:0] g, logic [31:0] data);
    issue(ioir_pkg::REQ_WRITE, g, ioir_pkg::OFF_WINDOW, data, 5'($urandom), 8'($urandom));
  endtask

  task automatic window_read(logic [1:0] g);
    issue(ioir_pkg::REQ_READ, g, ioir_pkg::OFF_WINDOW, $urandom, 5'($urandom), 8'($urandom));
  endtask

  task automatic pin_event(ioir_pkg::req_t rq, logic [1:0] g, logic [4:0] p);
    issue(rq, g, 5'($urandom), $urandom, p, 8'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_cfg(logic [ioir_pkg::CFG_IDX_W-1:0] idx, logic [7:0] value);
    drain();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  function automatic logic [7:0] entry_sel(int unsigned n, bit high);
    return ioir_pkg::SEL_TBL_BASE + 8'(2 * n) + 8'(high);
  endfunction

  function automatic logic [7:0] pick_select();
    case ($urandom_range(0, 5))
      0: return ioir_pkg::SEL_ID;
      1: return ioir_pkg::SEL_VERSION;
      2: return ioir_pkg::SEL_ARB;
      3, 4: return entry_sel($urandom_range(0, ioir_pkg::TABLE_ENTRIES - 1), 1'($urandom));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic run_traffic(int unsigned count, bit with_hold, bit with_pause);
    int unsigned target;
    int unsigned halfway;
    logic [1:0]  g;
    logic [4:0]  p;
    logic [4:0]  off;
    logic [31:0] lo;
    logic [31:0] hi;
    int unsigned n;
    target  = requests_sent + count;
    halfway = requests_sent + count / 2;
    while (requests_sent < target) begin
      if (requests_sent >= halfway) begin
        if (with_hold) begin
          hold_req <= 1'b1;
          with_hold = 1'b0;
        end
        if (with_pause) begin
          drain();
          with_pause = 1'b0;
        end
      end
      g = 2'($urandom);
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          n  = $urandom_range(0, ioir_pkg::TABLE_ENTRIES - 1);
          lo = $urandom;
          if ($urandom_range(0, 3) != 0) lo[ioir_pkg::E_MASK] = 1'b0;
          hi = $urandom;
          if ($urandom_range(0, 4) == 0) hi[31:24] = ioir_pkg::DEST_BROADCAST;
          write_index(g, entry_sel(n, 1'b0));
          window_write(g, lo);
          write_index(g, entry_sel(n, 1'b1));
          window_write(g, hi);
        end
        3, 4, 5: begin
          if ($urandom_range(0, 9) == 0) p = 5'($urandom_range(ioir_pkg::TABLE_ENTRIES, 31));
          else p = 5'($urandom_range(0, ioir_pkg::TABLE_ENTRIES - 1));
          pin_event(ioir_pkg::REQ_LOWER, g, p);
          pin_event(ioir_pkg::REQ_RAISE, g, p);
          if ($urandom_range(0, 2) == 0) pin_event(ioir_pkg::REQ_RAISE, 2'($urandom), p);
        end
        6: begin
          write_index(g, pick_select());
          window_read(g);
        end
        7: begin
          write_index(g, pick_select());
          window_write(g, $urandom);
        end
        8: begin
          if ($urandom_range(0, 1) == 0) begin
            issue(ioir_pkg::REQ_READ, g, ioir_pkg::OFF_INDEX, $urandom, 5'($urandom),
                  8'($urandom));
          end else begin
            off = 5'($urandom);
            if (off == ioir_pkg::OFF_INDEX || off == ioir_pkg::OFF_WINDOW) off[2] = 1'b1;
            issue($urandom_range(0, 1) ? ioir_pkg::REQ_READ : ioir_pkg::REQ_WRITE, g, off,
                  $urandom, 5'($urandom), 8'($urandom));
          end
        end
        default: issue(ioir_pkg::req_t'($urandom_range(0, 3)), g, 5'($urandom), $urandom,
                       5'($urandom), 8'($urandom));
      endcase
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    write_cfg(ioir_pkg::CFG_INITIAL_ID, 8'h5A);
    write_cfg(ioir_pkg::CFG_VERSION, 8'h00);

    // directed: register file corners, reserved bits, message special cases
    issue(ioir_pkg::REQ_READ, 2'd0, ioir_pkg::OFF_INDEX, 32'h0, 5'd0, 8'h0);
    write_index(2'd0, ioir_pkg::SEL_VERSION);
    window_read(2'd0);
    window_write(2'd0, 32'hFFFF_FFFF);
    issue(ioir_pkg::REQ_WRITE, 2'd0, 5'd31, 32'hFFFF_FFFF, 5'd31, 8'hFF);
    write_index(2'd0, 8'hFF);
    window_read(2'd0);
    window_write(2'd0, 32'hFFFF_FFFF);
    write_index(2'd0, entry_sel(ioir_pkg::TABLE_ENTRIES, 1'b0));
    window_read(2'd0);
    write_index(2'd1, entry_sel(ioir_pkg::TABLE_ENTRIES - 1, 1'b1));
    window_write(2'd1, 32'hFFFF_FFFF);
    window_read(2'd1);
    write_index(2'd1, entry_sel(ioir_pkg::TABLE_ENTRIES - 1, 1'b0));
    window_write(2'd1, 32'hFFFE_A7FF);
    window_read(2'd1);
    pin_event(ioir_pkg::REQ_RAISE, 2'd1, 5'(ioir_pkg::TABLE_ENTRIES - 1));
    pin_event(ioir_pkg::REQ_RAISE, 2'd1, 5'(ioir_pkg::TABLE_ENTRIES - 1));
    pin_event(ioir_pkg::REQ_LOWER, 2'd1, 5'(ioir_pkg::TABLE_ENTRIES - 1));
    pin_event(ioir_pkg::REQ_RAISE, 2'd2, 5'd24);
    pin_event(ioir_pkg::REQ_LOWER, 2'd2, 5'd31);
    pin_event(ioir_pkg::REQ_RAISE, 2'd2, 5'd0);
    write_index(2'd3, ioir_pkg::SEL_ARB);
    window_write(2'd3, 32'h00FF_FFFF);
    window_read(2'd3);

    write_cfg(ioir_pkg::CFG_INITIAL_ID, 8'd254);
    write_cfg(ioir_pkg::CFG_VERSION, 8'hFF);
    idle_pct = 25;
    run_traffic(200, 1'b1, 1'b0);

    write_cfg(ioir_pkg::CFG_INITIAL_ID, 8'd0);
    write_cfg(ioir_pkg::CFG_VERSION, ioir_pkg::VERSION_RESET);
    idle_pct = 50;
    run_traffic(200, 1'b0, 1'b1);

    write_cfg(ioir_pkg::CFG_INITIAL_ID, 8'($urandom_range(1, 253)));
    write_cfg(ioir_pkg::CFG_VERSION, 8'($urandom));
    idle_pct = 10;
    run_traffic(150, 1'b1, 1'b0);

    idle_pct = 0;
    run_traffic(150, 1'b0, 1'b0);

    drain();
    repeat (8) @(posedge clk);
    $display("Covered %0d requests across %0d config writes; %0d interrupt messages checked.",
             requests_sent, cfg_writes, irq_count);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[io_interrupt_redirector] OK");
    end else begin
      $display("[io_interrupt_redirector] ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/ioir_pkg.sv
design/ioir_ram.sv
design/ioir_ctrl.sv
design/ioir_dp.sv
design/io_interrupt_redirector.sv
verif/ioir_checker.sv
verif/tb_top.sv
